// ===== hdl/function_call_return_tracker_core_assert.svh =====
// assertion macros for the function call return tracker
`ifndef FUNCTION_CALL_RETURN_TRACKER_CORE_ASSERT_SVH
`define FUNCTION_CALL_RETURN_TRACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define FCRT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fcrt assertion failed");
`define FCRT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fcrt assertion failed");
`else
`define FCRT_ASSERT(label, clk, rst, prop)
`define FCRT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hdl/fcrt_pkg.sv =====
// shared types and constants for the function call return tracker
package fcrt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int STACK_DEPTH_DEF = 64;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PC   = 1'b1;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_CALL = 2'd1;
  localparam logic [1:0] EV_RET  = 2'd2;
  localparam logic [1:0] EV_OVF  = 2'd3;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        is_func;
    logic [31:0] name;
  } sym_entry_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_HIT  = 6'b000100,
    ST_STK  = 6'b001000,
    ST_PUSH = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

endpackage

// ===== hdl/function_call_return_tracker_core.sv =====
// function call return tracker: symbol table scan and call stack sequencer
//
// input channel (in_valid / in_stall): cmd 0 writes one symbol table slot,
// cmd 1 presents an executed pc. every input transaction yields exactly one
// output transaction (out_valid / out_stall) carrying event_res, depth,
// symbol_index, symbol_name and func_start.
// configuration channel (cfg_valid / cfg_ready, cfg_ready always high): writes
// symbol_count; the user must write it only while the block is idle, and the
// block itself does not enforce it. one item is worked on at a time; in_stall
// is high from acceptance until the result moves into the output register.
// sequence: a load passes from idle through the emit state to the output
// register. a pc goes through the scan, hit, stack read, push and emit states
// as needed, scanning the symbol table and then the call stack from the top down
// through the single read port of each ram, one compare per cycle.
// when the receiver stalls, the finished result waits in the sequencer and
// the output register holds its transaction until taken.
// reset (rst, synchronous) clears the depth, names, indexes, symbol_count
// and handshake state; the table and stack rams are not cleared and must be
// written before they are read.
module function_call_return_tracker_core #(
  parameter int TABLE_DEPTH = fcrt_pkg::TABLE_DEPTH_DEF,
  parameter int STACK_DEPTH = fcrt_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [5:0]  entry_index,
  input  logic [31:0] entry_start,
  input  logic [31:0] entry_size,
  input  logic        entry_is_func,
  input  logic [31:0] entry_name,
  input  logic [31:0] pc,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_res,
  output logic [6:0]  depth,
  output logic [5:0]  symbol_index,
  output logic [31:0] symbol_name,
  output logic [31:0] func_start
);

`include "function_call_return_tracker_core_assert.svh"

  localparam int TW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > 7) ? CW : 7;
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int EW = $bits(fcrt_pkg::sym_entry_t);

  fcrt_pkg::state_t state;

  logic [6:0]  symbol_count;
  logic [DW-1:0] stack_depth;
  logic [31:0] cur_name;
  logic [31:0] prev_name;
  logic [5:0]  cur_index;
  logic [5:0]  prev_index;

  logic [31:0] pc_q;
  logic [CW-1:0] limit;
  logic [CW-1:0] ra;
  logic [TW-1:0] ca;
  logic          rv;
  logic [SW-1:0] sa;
  logic [SW-1:0] sca;
  logic          s_more;
  logic          first;
  fcrt_pkg::sym_entry_t hit_entry;
  logic [TW-1:0] hit_idx;

  logic [1:0]  res_event;
  logic [5:0]  res_index;
  logic [31:0] res_name;
  logic [31:0] res_start;

  logic          tbl_we;
  logic [TW-1:0] tbl_waddr;
  logic          tbl_re;
  logic [TW-1:0] tbl_raddr;
  fcrt_pkg::sym_entry_t tbl_wdata;
  logic [EW-1:0] tbl_rdata_raw;
  fcrt_pkg::sym_entry_t tbl_rdata;

  logic          stk_we;
  logic [SW-1:0] stk_waddr;
  logic [31:0]   stk_wdata;
  logic          stk_re;
  logic [SW-1:0] stk_raddr;
  logic [31:0]   stk_rdata;

  logic [TW+5:0] slot_ext;
  logic          slot_ok;
  logic [TW+5:0] hit_idx_ext;
  logic [DW+6:0] depth_ext;
  logic [CW-1:0] limit_calc;
  logic          scan_issue;
  logic [32:0]   range_end;
  logic          range_hit;
  logic          in_accept;
  logic          out_free;
  logic [DW-1:0] depth_m1;

  assign cfg_ready   = 1'b1;
  assign in_stall    = (state != fcrt_pkg::ST_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;

  assign slot_ext    = {{TW{1'b0}}, entry_index};
  assign slot_ok     = (slot_ext < (TW + 6)'(TABLE_DEPTH));
  assign hit_idx_ext = {6'b0, hit_idx};
  assign depth_ext   = {7'b0, stack_depth};
  assign depth_m1    = stack_depth - 1'b1;

  always_comb begin
    if (LW'(symbol_count) >= LW'(TABLE_DEPTH)) begin
      limit_calc = CW'(TABLE_DEPTH);
    end else begin
      limit_calc = CW'(symbol_count);
    end
  end

  assign tbl_rdata  = fcrt_pkg::sym_entry_t'(tbl_rdata_raw);
  assign scan_issue = (state == fcrt_pkg::ST_SCAN) && (ra < limit);
  assign range_end  = {1'b0, tbl_rdata.start} + {1'b0, tbl_rdata.size};
  assign range_hit  = tbl_rdata.is_func && (pc_q >= tbl_rdata.start) &&
                      ({1'b0, pc_q} < range_end);

  assign tbl_we    = in_accept && (cmd == fcrt_pkg::CMD_LOAD) && slot_ok;
  assign tbl_waddr = slot_ext[TW-1:0];
  assign tbl_wdata = '{start: entry_start, size: entry_size,
                       is_func: entry_is_func, name: entry_name};
  assign tbl_re    = scan_issue;
  assign tbl_raddr = ra[TW-1:0];

  assign stk_re    = (state == fcrt_pkg::ST_STK) && s_more;
  assign stk_raddr = sa;

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = cur_name;
    case (state)
      fcrt_pkg::ST_HIT: begin
        if (hit_entry.name != cur_name && stack_depth == '0) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = hit_entry.name;
        end
      end
      fcrt_pkg::ST_PUSH: begin
        if (stack_depth < DW'(STACK_DEPTH)) begin
          stk_we    = 1'b1;
          stk_waddr = stack_depth[SW-1:0];
          stk_wdata = cur_name;
        end
      end
      default: begin
        stk_we = 1'b0;
      end
    endcase
  end

  fcrt_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (tbl_we),
    .wr_addr(tbl_waddr),
    .wr_data(tbl_wdata),
    .rd_en  (tbl_re),
    .rd_addr(tbl_raddr),
    .rd_data(tbl_rdata_raw)
  );

  fcrt_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .wr_en  (stk_we),
    .wr_addr(stk_waddr),
    .wr_data(stk_wdata),
    .rd_en  (stk_re),
    .rd_addr(stk_raddr),
    .rd_data(stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fcrt_pkg::ST_IDLE;
      out_valid    <= 1'b0;
      symbol_count <= '0;
      stack_depth  <= '0;
      cur_name     <= '0;
      prev_name    <= '0;
      cur_index    <= '0;
      prev_index   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        symbol_count <= cfg_data;
      end
      if (out_valid && !out_stall && state != fcrt_pkg::ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        fcrt_pkg::ST_IDLE: begin
          if (in_accept) begin
            res_event <= fcrt_pkg::EV_NONE;
            res_index <= '0;
            res_name  <= '0;
            res_start <= '0;
            pc_q      <= pc;
            limit     <= limit_calc;
            ra        <= '0;
            rv        <= 1'b0;
            if (cmd == fcrt_pkg::CMD_PC && limit_calc != '0) begin
              state <= fcrt_pkg::ST_SCAN;
            end else begin
              state <= fcrt_pkg::ST_EMIT;
            end
          end
        end
        fcrt_pkg::ST_SCAN: begin
          rv <= scan_issue;
          if (scan_issue) begin
            ra <= ra + 1'b1;
            ca <= ra[TW-1:0];
          end
          if (rv) begin
            if (range_hit) begin
              hit_entry <= tbl_rdata;
              hit_idx   <= ca;
              state     <= fcrt_pkg::ST_HIT;
            end else if (!scan_issue) begin
              state <= fcrt_pkg::ST_EMIT;
            end
          end
        end
        fcrt_pkg::ST_HIT: begin
          prev_name  <= cur_name;
          cur_name   <= hit_entry.name;
          prev_index <= cur_index;
          cur_index  <= hit_idx_ext[5:0];
          sa         <= depth_m1[SW-1:0];
          s_more     <= 1'b1;
          first      <= 1'b1;
          rv         <= 1'b0;
          if (hit_entry.name == cur_name) begin
            state <= fcrt_pkg::ST_EMIT;
          end else if (stack_depth == '0) begin
            stack_depth <= DW'(1);
            res_event   <= fcrt_pkg::EV_CALL;
            res_index   <= hit_idx_ext[5:0];
            res_name    <= hit_entry.name;
            res_start   <= hit_entry.start;
            state       <= fcrt_pkg::ST_EMIT;
          end else begin
            state <= fcrt_pkg::ST_STK;
          end
        end
        fcrt_pkg::ST_STK: begin
          rv <= s_more;
          if (s_more) begin
            sca <= sa;
            if (sa == '0) begin
              s_more <= 1'b0;
            end else begin
              sa <= sa - 1'b1;
            end
          end
          if (rv) begin
            first <= 1'b0;
            if (first && stk_rdata != prev_name) begin
              state <= fcrt_pkg::ST_EMIT;
            end else if (!first && stk_rdata == cur_name) begin
              stack_depth <= DW'(sca) + 1'b1;
              res_event   <= fcrt_pkg::EV_RET;
              res_index   <= prev_index;
              res_name    <= prev_name;
              state       <= fcrt_pkg::ST_EMIT;
            end else if (!s_more) begin
              state <= fcrt_pkg::ST_PUSH;
            end
          end
        end
        fcrt_pkg::ST_PUSH: begin
          res_index <= cur_index;
          res_name  <= cur_name;
          if (stack_depth < DW'(STACK_DEPTH)) begin
            stack_depth <= stack_depth + 1'b1;
            res_event   <= fcrt_pkg::EV_CALL;
            res_start   <= hit_entry.start;
          end else begin
            res_event <= fcrt_pkg::EV_OVF;
          end
          state <= fcrt_pkg::ST_EMIT;
        end
        fcrt_pkg::ST_EMIT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            event_res    <= res_event;
            depth        <= depth_ext[6:0];
            symbol_index <= res_index;
            symbol_name  <= res_name;
            func_start   <= res_start;
            state        <= fcrt_pkg::ST_IDLE;
          end else if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
        end
        default: begin
          state <= fcrt_pkg::ST_IDLE;
        end
      endcase
    end
  end

  `FCRT_ASSERT(a_accept_leaves_idle, clk, rst,
    in_accept |=> state != fcrt_pkg::ST_IDLE)
  `FCRT_ASSERT(a_idle_depth_stable, clk, rst,
    (state == fcrt_pkg::ST_IDLE) |=> $stable(stack_depth))
  `FCRT_ASSERT(a_emit_waits_on_stall, clk, rst,
    (state == fcrt_pkg::ST_EMIT && out_valid && out_stall) |=> state == fcrt_pkg::ST_EMIT)
  `FCRT_ASSERT(a_overflow_full, clk, rst,
    (state == fcrt_pkg::ST_EMIT && res_event == fcrt_pkg::EV_OVF) |->
      stack_depth == DW'(STACK_DEPTH))
  `FCRT_ASSERT_ALWAYS(a_depth_bound, clk,
    rst || stack_depth <= DW'(STACK_DEPTH))

endmodule

// ===== hdl/fcrt_ram.sv =====
// generic single write port ram with registered read
module fcrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== tb/tb_function_call_return_tracker_core.sv =====
// self-checking testbench for the function call return tracker core
`timescale 1ns / 100ps

module tb_function_call_return_tracker_core;

  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 140;
  localparam int PHASES = 8;
  localparam int PHASE_COUNT [PHASES] = '{64, 6, 0, 64, 47, 64, 16, 1};

  typedef struct packed {
    logic        cmd;
    logic [5:0]  entry_index;
    logic [31:0] entry_start;
    logic [31:0] entry_size;
    logic        entry_is_func;
    logic [31:0] entry_name;
    logic [31:0] pc;
  } tracker_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [6:0]  depth;
    logic [5:0]  symbol_index;
    logic [31:0] symbol_name;
    logic [31:0] func_start;
  } trace_result_t;

  class call_trace_scoreboard;
    fcrt_pkg::sym_entry_t symtab [fcrt_pkg::TABLE_DEPTH_DEF];
    logic [31:0]   name_stack [fcrt_pkg::STACK_DEPTH_DEF];
    int unsigned   stack_depth = 0;
    logic [31:0]   cur_name = '0;
    logic [31:0]   prev_name = '0;
    logic [5:0]    cur_idx = '0;
    logic [5:0]    prev_idx = '0;
    int unsigned   scan_count = 0;
    trace_result_t expected_events [$];
    int unsigned   errors = 0;

    function void set_symbol_count(logic [6:0] value);
      scan_count = value;
    endfunction

    function void predict_event(tracker_item_t it);
      trace_result_t r;
      fcrt_pkg::sym_entry_t e;
      int unsigned   lim;
      int            hit;
      bit            found;
      bit            ret;
      r = '0;
      hit = 0;
      found = 1'b0;
      ret = 1'b0;
      if (it.cmd == fcrt_pkg::CMD_LOAD) begin
        symtab[it.entry_index] = '{start: it.entry_start, size: it.entry_size,
                                   is_func: it.entry_is_func, name: it.entry_name};
      end else begin
        lim = (scan_count < fcrt_pkg::TABLE_DEPTH_DEF) ? scan_count
                                                       : fcrt_pkg::TABLE_DEPTH_DEF;
        for (int i = 0; i < lim && !found; i++) begin
          e = symtab[i];
          if (e.is_func && it.pc >= e.start &&
              {1'b0, it.pc} < {1'b0, e.start} + {1'b0, e.size}) begin
            hit = i;
            found = 1'b1;
          end
        end
        if (found) begin
          e = symtab[hit];
          prev_name = cur_name;
          cur_name = e.name;
          prev_idx = cur_idx;
          cur_idx = hit[5:0];
          if (cur_name != prev_name &&
              (stack_depth == 0 || name_stack[stack_depth - 1] == prev_name)) begin
            // search downward for the new name: a hit is a return
            for (int j = stack_depth; j > 0 && !ret; j--) begin
              if (name_stack[j - 1] == cur_name) begin
                stack_depth = j;
                ret = 1'b1;
              end
            end
            if (ret) begin
              r.event_res = fcrt_pkg::EV_RET;
              r.symbol_index = prev_idx;
              r.symbol_name = prev_name;
            end else if (stack_depth >= fcrt_pkg::STACK_DEPTH_DEF) begin
              r.event_res = fcrt_pkg::EV_OVF;
              r.symbol_index = cur_idx;
              r.symbol_name = cur_name;
            end else begin
              name_stack[stack_depth] = cur_name;
              stack_depth++;
              r.event_res = fcrt_pkg::EV_CALL;
              r.symbol_index = cur_idx;
              r.symbol_name = cur_name;
              r.func_start = e.start;
            end
          end
        end
      end
      r.depth = stack_depth[6:0];
      expected_events.push_back(r);
    endfunction

    function void report_field(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_event(trace_result_t got);
      trace_result_t want;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual event %0d depth %0d",
                 $time, got.event_res, got.depth);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      if (got.event_res !== want.event_res)
        report_field("event_res", want.event_res, got.event_res);
      if (got.depth !== want.depth) report_field("depth", want.depth, got.depth);
      if (got.symbol_index !== want.symbol_index)
        report_field("symbol_index", want.symbol_index, got.symbol_index);
      if (got.symbol_name !== want.symbol_name)
        report_field("symbol_name", want.symbol_name, got.symbol_name);
      if (got.func_start !== want.func_start)
        report_field("func_start", want.func_start, got.func_start);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = fcrt_pkg::CMD_LOAD;
  logic [5:0]  entry_index = '0;
  logic [31:0] entry_start = '0;
  logic [31:0] entry_size = '0;
  logic        entry_is_func = 1'b0;
  logic [31:0] entry_name = '0;
  logic [31:0] pc = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_res;
  logic [6:0]  depth;
  logic [5:0]  symbol_index;
  logic [31:0] symbol_name;
  logic [31:0] func_start;

  call_trace_scoreboard sb = new;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          cur_count = 0;
  bit          slot_written [fcrt_pkg::TABLE_DEPTH_DEF];
  logic [31:0] region_base = '0;
  logic [31:0] name_seed = 32'h4000_0000;
  int unsigned quiet_cycles = 0;

  function_call_return_tracker_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .entry_index  (entry_index),
    .entry_start  (entry_start),
    .entry_size   (entry_size),
    .entry_is_func(entry_is_func),
    .entry_name   (entry_name),
    .pc           (pc),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .depth        (depth),
    .symbol_index (symbol_index),
    .symbol_name  (symbol_name),
    .func_start   (func_start)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_event(trace_result_t'({event_res, depth, symbol_index, symbol_name,
                                      func_start}));
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(input tracker_item_t item);
    if (!in_valid) in_valid <= 1'b1;
    cmd <= item.cmd;
    entry_index <= item.entry_index;
    entry_start <= item.entry_start;
    entry_size <= item.entry_size;
    entry_is_func <= item.entry_is_func;
    entry_name <= item.entry_name;
    pc <= item.pc;
    do @(posedge clk); while (in_stall);
    sb.predict_event(item);
    if (item.cmd == fcrt_pkg::CMD_LOAD) slot_written[item.entry_index] = 1'b1;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic load_slot(input int slot, input logic [31:0] start, input logic [31:0] size,
                           input logic is_func, input logic [31:0] name);
    tracker_item_t it;
    it = '{cmd: fcrt_pkg::CMD_LOAD, entry_index: slot[5:0], entry_start: start,
           entry_size: size, entry_is_func: is_func, entry_name: name, pc: $urandom};
    send_item(it);
  endtask

  task automatic send_pc(input logic [31:0] addr);
    tracker_item_t it;
    it = '{cmd: fcrt_pkg::CMD_PC, entry_index: 6'($urandom), entry_start: $urandom,
           entry_size: $urandom, entry_is_func: 1'($urandom), entry_name: $urandom,
           pc: addr};
    send_item(it);
  endtask

  // disjoint per-slot regions above the phase base
  task automatic load_layout(input int slot, input logic [31:0] name, input logic is_func);
    load_slot(slot, region_base + slot * 32'h400, $urandom_range(1, 32'h400), is_func, name);
  endtask

  function automatic logic [31:0] pc_within(input int slot);
    fcrt_pkg::sym_entry_t e;
    e = sb.symtab[slot];
    if (e.size == 0) return e.start;
    return e.start + ($urandom % e.size);
  endfunction

  function automatic logic [31:0] next_fresh_name();
    name_seed = name_seed + 1;
    return name_seed;
  endfunction

  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_symbol_count(input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_symbol_count(value);
    cur_count = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_table();
    for (int s = 0; s < cur_count; s++)
      if (!slot_written[s]) load_layout(s, $urandom_range(15), 1'b1);
  endtask

  // fresh names in slots 1 and up (slot 0 reuses the top of stack name, if any)
  // drive the stack to full, then overflow, a stale top of stack, and a deep return
  task automatic deep_walk();
    load_layout(0, (sb.stack_depth > 0) ? sb.name_stack[sb.stack_depth - 1]
                                         : next_fresh_name(), 1'b1);
    for (int s = 1; s < fcrt_pkg::TABLE_DEPTH_DEF; s++)
      load_layout(s, next_fresh_name(), 1'b1);
    for (int s = 0; s < fcrt_pkg::TABLE_DEPTH_DEF; s++) send_pc(pc_within(s));
    load_layout(1, next_fresh_name(), 1'b1);
    send_pc(pc_within(1));
    send_pc(pc_within(2));
    send_pc(pc_within(63));
    send_pc(pc_within(5));
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 6)
      load_slot($urandom_range(63), $urandom, $urandom, 1'($urandom_range(1)), $urandom);
    else if (r < 14)
      load_layout($urandom_range(63), $urandom_range(15), $urandom_range(7) != 0);
    else if (r < 18 && sb.stack_depth > 0 && cur_count > 0)
      load_layout($urandom_range(cur_count - 1), sb.name_stack[sb.stack_depth - 1], 1'b1);
    else if (r < 28 || cur_count == 0)
      send_pc($urandom);
    else
      send_pc(pc_within($urandom_range(cur_count - 1)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_symbol_count(7'd8);
    load_slot(0, 32'h1000, 32'h100, 1'b1, 32'hA);
    load_slot(1, 32'h2000, 32'h100, 1'b1, 32'hB);
    load_slot(2, 32'h3000, 32'h100, 1'b0, 32'hC);
    load_slot(3, 32'h3000, 32'h80, 1'b1, 32'hD);
    load_slot(4, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    load_slot(5, 32'h0, 32'h10, 1'b1, 32'h0);
    load_slot(6, 32'h1000, 32'h10, 1'b1, 32'h1234);
    load_slot(7, 32'h5000, 32'h0, 1'b1, 32'hE);
    load_slot(63, 32'hFFFF_FFFF, 32'h1, 1'b1, 32'h5A5A_5A5A);
    send_pc(32'h8);
    send_pc(32'h1000);
    send_pc(32'h10FF);
    send_pc(32'h1100);
    send_pc(32'h2000);
    send_pc(32'h3000);
    send_pc(32'h1004);
    send_pc(32'hFFFF_FFFF);
    send_pc(32'h0);
    send_pc(32'h5000);
    send_pc(32'h20);
    send_pc(32'h2050);
    send_pc(32'h1000);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      sender_idle_pct = (p % 4 == 1) ? 71 : (p % 4 == 3) ? 18 : 0;
      recv_stall_pct = (p % 4 == 2) ? 71 : (p % 4 == 3) ? 18 : 0;
      region_base = $urandom_range(12'hFFE) << 20;
      write_symbol_count(7'(PHASE_COUNT[p]));
      fill_table();
      if (cur_count == fcrt_pkg::TABLE_DEPTH_DEF) deep_walk();
      repeat ((cur_count == 0) ? 40 : 170) random_item();
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== function_call_return_tracker_core.f =====
+incdir+hdl
hdl/fcrt_pkg.sv
hdl/fcrt_ram.sv
hdl/function_call_return_tracker_core.sv
tb/tb_function_call_return_tracker_core.sv
